>>> rtl/core/form_query_pair_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Form query pair decoder: assertion macros
// Shared concurrent assertion forms for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef FORM_QUERY_PAIR_DECODER_UNIT_MACROS_SVH
`define FORM_QUERY_PAIR_DECODER_UNIT_MACROS_SVH

// property checked outside reset
`define FQPD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("fqpd assertion failed");

// property that also looks at reset itself
`define FQPD_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("fqpd reset assertion failed");

`endif

>>> rtl/core/fqpd_pkg.sv
// ----------------------------------------------------------------------------
// fqpd_pkg
// Types, character codes and helpers of the form query pair decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fqpd_pkg;

   localparam logic [7:0] CHAR_AMP   = 8'h26;  // '&'
   localparam logic [7:0] CHAR_EQ    = 8'h3D;  // '='
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_PCT   = 8'h25;  // '%'
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_PCT   = 2'd1;
   localparam logic [1:0] ESC_DIGIT = 2'd2;

   localparam int unsigned MAX_RESULTS = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_query;
   } req_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic       in_value_part;
      logic       pair_end;
      logic       run_last;
   } rsp_type;

   // 0..15 for a hex digit of either case, 16 otherwise
   function automatic logic [4:0] hex_of(input logic [7:0] c);
      logic [4:0] h;
      h = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) begin
         h = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h = {1'b0, 4'(c - 8'h37)};
      end
      return h;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/form_query_pair_decoder_unit.sv
// Timing: an accepted request is captured in the input register; once the
// result buffer can load, its results are registered there and shown on rsp_.
// Throughput: one request per cycle while rsp_stall is low and each causes at
// most one result; a request's k results (k up to 4) hold the buffer until popped.
// Reset: synchronous; clears parse state, input and result valid flags.
// ----------------------------------------------------------------------------
// form_query_pair_decoder_unit
// Streaming decoder for form-encoded query strings: splits pairs at '&',
// key/value at the first '=', decodes '+' and %XX, tags every byte.
// ----------------------------------------------------------------------------
`default_nettype none

module form_query_pair_decoder_unit
   import fqpd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // parse state
   logic       value_side_ff, value_side_in;
   logic       seg_nonempty_ff, seg_nonempty_in;
   logic [1:0] esc_ff, esc_in;
   logic [7:0] digit_ff, digit_in;

   // result buffer, head at entry 0
   rsp_type    res_ff [MAX_RESULTS];
   rsp_type    res_new [MAX_RESULTS];
   logic [2:0] rem_ff, rem_in;
   logic [2:0] n_new;

   logic pop, load, accept;

   assign pop       = (rem_ff != 3'd0) && !rsp_stall;
   assign load      = in_valid_ff && ((rem_ff == 3'd0) || ((rem_ff == 3'd1) && pop));
   assign req_stall = in_valid_ff && !load;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (rem_ff != 3'd0);
   assign rsp_data  = res_ff[0];

   // single-pass decode of the registered byte
   always_comb begin
      logic [7:0] c;
      logic [4:0] h;
      logic [4:0] hh;
      logic       vs, ne, fresh;
      logic [1:0] ep;
      logic [7:0] hd;
      logic [2:0] n;
      rsp_type    res [MAX_RESULTS];

      c     = in_data_ff.in_byte;
      h     = hex_of(c);
      vs    = value_side_ff;
      ne    = seg_nonempty_ff;
      ep    = esc_ff;
      hd    = digit_ff;
      hh    = hex_of(hd);
      n     = 3'd0;
      fresh = 1'b0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end

      unique case (ep)
         ESC_PCT: begin
            if (!h[4]) begin
               ep = ESC_DIGIT;
               hd = c;
            end else begin
               res[n[1:0]] = '{1'b1, CHAR_PCT, vs, 1'b0, 1'b0};
               n = n + 3'd1;
               ep = ESC_NONE;
               fresh = 1'b1;
            end
         end
         ESC_DIGIT: begin
            if (!h[4]) begin
               res[n[1:0]] = '{1'b1, {hh[3:0], h[3:0]}, vs, 1'b0, 1'b0};
               n = n + 3'd1;
               ep = ESC_NONE;
               hd = 8'd0;
            end else begin
               res[n[1:0]] = '{1'b1, CHAR_PCT, vs, 1'b0, 1'b0};
               n = n + 3'd1;
               res[n[1:0]] = '{1'b1, hd, vs, 1'b0, 1'b0};
               n = n + 3'd1;
               ep = ESC_NONE;
               hd = 8'd0;
               fresh = 1'b1;
            end
         end
         default: begin
            ep = ESC_NONE;
            fresh = 1'b1;
         end
      endcase

      if (fresh) begin
         priority if (c == CHAR_AMP) begin
            if (ne) begin
               res[n[1:0]] = '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0};
               n = n + 3'd1;
            end
            vs = 1'b0;
            ne = 1'b0;
         end else if (c == CHAR_EQ && !vs) begin
            ne = 1'b1;
            vs = 1'b1;
         end else if (c == CHAR_PCT) begin
            ne = 1'b1;
            ep = ESC_PCT;
         end else if (c == CHAR_PLUS) begin
            ne = 1'b1;
            res[n[1:0]] = '{1'b1, CHAR_SPACE, vs, 1'b0, 1'b0};
            n = n + 3'd1;
         end else begin
            ne = 1'b1;
            res[n[1:0]] = '{1'b1, c, vs, 1'b0, 1'b0};
            n = n + 3'd1;
         end
      end

      // end of string: flush held escape, close segment, back to reset state
      if (in_data_ff.end_of_query) begin
         if (ep != ESC_NONE) begin
            res[n[1:0]] = '{1'b1, CHAR_PCT, vs, 1'b0, 1'b0};
            n = n + 3'd1;
         end
         if (ep == ESC_DIGIT) begin
            res[n[1:0]] = '{1'b1, hd, vs, 1'b0, 1'b0};
            n = n + 3'd1;
         end
         if (ne) begin
            res[n[1:0]] = '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0};
            n = n + 3'd1;
         end
         vs = 1'b0;
         ne = 1'b0;
         ep = ESC_NONE;
         hd = 8'd0;
      end

      if (n != 3'd0) begin
         res[2'(n - 3'd1)].run_last = 1'b1;
      end

      res_new         = res;
      n_new           = n;
      value_side_in   = vs;
      seg_nonempty_in = ne;
      esc_in          = ep;
      digit_in        = hd;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rem_in = rem_ff;
      if (load) begin
         rem_in = n_new;
      end else if (pop) begin
         rem_in = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rem_ff          <= 3'd0;
         value_side_ff   <= 1'b0;
         seg_nonempty_ff <= 1'b0;
         esc_ff          <= ESC_NONE;
         digit_ff        <= 8'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         rem_ff      <= rem_in;
         if (load) begin
            value_side_ff   <= value_side_in;
            seg_nonempty_ff <= seg_nonempty_in;
            esc_ff          <= esc_in;
            digit_ff        <= digit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (load) begin
         res_ff <= res_new;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            res_ff[i] <= res_ff[i + 1];
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/fqpd_checker.sv
// ----------------------------------------------------------------------------
// fqpd_checker
// Port-level assertions for the form query pair decoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "form_query_pair_decoder_unit_macros.svh"

module fqpd_checker
   import fqpd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic pair_end_seen;
   logic pair_end_zero;

   assign pair_end_seen = rsp_valid && rsp_data.pair_end;
   assign pair_end_zero = (rsp_data.out_byte == 8'd0) && !rsp_data.in_value_part;

   // a stalled request must not change
   `FQPD_ASSERT(a_req_hold, req_valid && req_stall |=> req_valid && $stable(req_data))

   // a held result must not change under stall
   `FQPD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // every result is either a decoded byte or a pair end, never both
   `FQPD_ASSERT(a_kind, rsp_valid |-> (rsp_data.has_byte != rsp_data.pair_end))

   // pair end markers carry zeroed payload and always close a request's results
   `FQPD_ASSERT(a_pair_end_clean, pair_end_seen |-> pair_end_zero && rsp_data.run_last)

   // reset empties both the input register and the result buffer
   `FQPD_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid && !req_stall)

endmodule

bind form_query_pair_decoder_unit fqpd_checker u_fqpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
